// ===== design/sorted_min_priority_queue_core_macros.svh =====
// Assertion macros shared by the queue RTL.
`ifndef SORTED_MIN_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_MIN_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define SMPQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("queue assertion failed");
// Next-cycle implication, disabled while reset is high.
`define SMPQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("queue assertion failed");
`else
`define SMPQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define SMPQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/smpq_pkg.sv =====
`default_nettype none

package smpq_pkg;

   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;
   localparam logic signed [VALUE_W-1:0] ENQ_VALUE   = 32'sd0;

   // Command broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic                       enq;
      logic                       deq;
      logic signed [VALUE_W-1:0]  value;
   } smpq_cmd_type;

endpackage

`default_nettype wire

// ===== design/smpq_cell.sv =====
`default_nettype none

module smpq_cell
   import smpq_pkg::*;
(
   input  wire logic                      clock,
   input  wire smpq_cmd_type              cmd,
   input  wire logic                      occupied,
   input  wire logic                      at_tail,
   input  wire logic                      prev_gt,
   input  wire logic signed [VALUE_W-1:0] prev_value,
   input  wire logic signed [VALUE_W-1:0] next_value,
   output logic signed [VALUE_W-1:0]      value_out,
   output logic                           gt_out
);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      take;

   // The array is sorted, so the cells holding entries larger than the new
   // value form one contiguous run at the back of the occupied region.
   assign gt_out    = occupied && ($signed(value_ff) > $signed(cmd.value));
   assign take      = gt_out || at_tail;
   assign value_out = value_ff;

   always_comb begin
      value_in = value_ff;
      if (cmd.enq && take) begin
         value_in = prev_gt ? prev_value : cmd.value;
      end else if (cmd.deq) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

// ===== design/sorted_min_priority_queue_core.sv =====
// Sorted minimum priority queue.
// Input channel (req_valid/req_ready): req_op selects enqueue of req_value
// or dequeue of the smallest entry. Result channel (rsp_valid/rsp_ready):
// one beat per request with rsp_result_value and rsp_status (ok, full on a
// rejected enqueue, empty on a dequeue from an empty queue, which returns -1).
// csr_we/csr_wdata write the capacity limit; the effective limit is the
// smaller of that value and DEPTH.
// The registered result is valid in the cycle after accept. Throughput is
// one item per cycle unless the receiver stalls: each of the DEPTH cells
// compares its entry with the new value and takes its neighbor's entry or
// the new value in the same cycle; a dequeue shifts the whole chain forward.
// The result sits in an output register; a new request is taken in the
// cycle that register is empty or being drained, so a stalled receiver
// stalls the requester after one held result.
// Synchronous reset empties the queue, sets capacity to 16 and drops any
// pending result. No clearing pass is needed.
`default_nettype none

`include "sorted_min_priority_queue_core_macros.svh"

module sorted_min_priority_queue_core
   import smpq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_op,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [VALUE_W-1:0]      rsp_result_value,
   output logic [STATUS_W-1:0]            rsp_status,
   input  wire logic                      csr_we,
   input  wire logic [CAP_W-1:0]          csr_wdata
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > CAP_W) ? CW : CAP_W;

   logic [CW-1:0]             occ_ff, occ_in;
   logic [CAP_W-1:0]          capacity_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;

   logic                      accept;
   logic                      full;
   logic                      empty;
   smpq_cmd_type              cmd;

   logic signed [VALUE_W-1:0] cell_value [DEPTH];
   logic                      cell_gt    [DEPTH];

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign full  = (LW'(occ_ff) >= LW'(capacity_ff)) || (occ_ff == CW'(DEPTH));
   assign empty = (occ_ff == '0);

   assign cmd.enq   = accept && (req_op == OP_ENQUEUE) && !full;
   assign cmd.deq   = accept && (req_op == OP_DEQUEUE) && !empty;
   assign cmd.value = req_value;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                      prev_gt;
      logic signed [VALUE_W-1:0] prev_value;
      logic signed [VALUE_W-1:0] next_value;

      if (i == 0) begin : g_head
         assign prev_gt    = 1'b0;
         assign prev_value = cell_value[0];
      end else begin : g_body
         assign prev_gt    = cell_gt[i-1];
         assign prev_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_value = cell_value[i];
      end else begin : g_mid
         assign next_value = cell_value[i+1];
      end

      smpq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (CW'(i) < occ_ff),
         .at_tail    (CW'(i) == occ_ff),
         .prev_gt    (prev_gt),
         .prev_value (prev_value),
         .next_value (next_value),
         .value_out  (cell_value[i]),
         .gt_out     (cell_gt[i])
      );
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.enq) begin
         occ_in = occ_ff + CW'(1);
      end else if (cmd.deq) begin
         occ_in = occ_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         unique case (req_op)
            OP_ENQUEUE: begin
               rsp_value_in  = ENQ_VALUE;
               rsp_status_in = full ? ST_FULL : ST_OK;
            end
            OP_DEQUEUE: begin
               rsp_value_in  = empty ? EMPTY_VALUE : cell_value[0];
               rsp_status_in = empty ? ST_EMPTY : ST_OK;
            end
            default: begin
               rsp_value_in  = ENQ_VALUE;
               rsp_status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   `SMPQ_ASSERT_IMP(a_occ_bound, clock, reset, 1'b1, occ_ff <= CW'(DEPTH))
   `SMPQ_ASSERT_NXT(a_enq_grows, clock, reset, cmd.enq, occ_ff == $past(occ_ff) + CW'(1))
   `SMPQ_ASSERT_NXT(a_full_holds, clock, reset, accept && (req_op == OP_ENQUEUE) && full, (occ_ff == $past(occ_ff)) && (rsp_status == ST_FULL))
   `SMPQ_ASSERT_NXT(a_empty_deq, clock, reset, accept && (req_op == OP_DEQUEUE) && empty, rsp_valid && (rsp_status == ST_EMPTY) && (rsp_result_value == EMPTY_VALUE))

endmodule

`default_nettype wire
